// ===== design/hthc_pkg.sv =====
// ----------------------------------------------------------------------------
// hthc_pkg: heading turn-and-hold controller package
// Field widths, fixed-point heading constants, operation, segment and
// register codes shared by the controller core.
// ----------------------------------------------------------------------------
package hthc_pkg;

  // field widths
  localparam int OP_W      = 2;
  localparam int HEAD_W    = 14;
  localparam int PULSE_W   = 16;
  localparam int DELTA_W   = 12;
  localparam int SPD_W     = 9;
  localparam int TRAV_W    = 31;
  localparam int S_DATA_W  = 72;
  localparam int M_DATA_W  = 56;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // register widths
  localparam int TOL_W     = 12;
  localparam int SPEED_W   = 7;
  localparam int SETTLE_W  = 8;
  localparam int TIMEOUT_W = 16;
  localparam int TRIM_W    = 5;

  // default odometer width
  localparam int ODOMETER_BITS_DEF = 32;

  // heading fixed point: fraction bits and turn sizes
  localparam int HEADING_FRAC_BITS = 4;
  localparam int HALF_TURN = 180 << HEADING_FRAC_BITS;
  localparam int FULL_TURN = 360 << HEADING_FRAC_BITS;

  // raw heading error: goal minus heading over two full-range headings
  localparam int ERR_W = HEAD_W + 2;
  localparam int ERR_SPAN = 1 << HEAD_W;
  localparam int WRAP_STEPS = (ERR_SPAN - HALF_TURN + FULL_TURN - 1) / FULL_TURN;
  localparam logic signed [ERR_W-1:0] HALF_TURN_E     = ERR_W'(HALF_TURN);
  localparam logic signed [ERR_W-1:0] NEG_HALF_TURN_E = ERR_W'(-HALF_TURN);
  localparam logic signed [ERR_W-1:0] FULL_TURN_E     = ERR_W'(FULL_TURN);

  // magnitude of a wrapped error
  localparam int ABS_W = $clog2(HALF_TURN + 1);

  // turn speed: 0.8 * error in degrees = (4 * err) / (5 << frac)
  localparam int TURN_DIV   = 5 << HEADING_FRAC_BITS;
  localparam int TURN_NUM_W = ABS_W + 2;
  localparam int TURN_SHIFT = TURN_NUM_W + 4;
  localparam int TURN_RECIP = ((1 << TURN_SHIFT) + TURN_DIV - 1) / TURN_DIV;
  localparam int RECIP_W    = $clog2(TURN_RECIP + 1);
  localparam int TURN_Q_W   = $clog2((4 * HALF_TURN) / TURN_DIV + 1);

  // heading hold: 0.5 * error in degrees = err / (2 << frac), toward zero
  localparam int HOLD_SHIFT = HEADING_FRAC_BITS + 1;
  localparam int HOLD_BIAS  = (1 << HOLD_SHIFT) - 1;

  // straight wheel speed sum and cap
  localparam int SUM_W = SPEED_W + 3;
  localparam int STRAIGHT_SPEED_CAP = 120;

  // travelled count ceiling
  localparam logic [TRAV_W-1:0] TRAVEL_MAX = {TRAV_W{1'b1}};

  // register reset values
  localparam logic [TOL_W-1:0]     TOL_RST     = TOL_W'(48);
  localparam logic [SPEED_W-1:0]   MIN_SPD_RST = SPEED_W'(15);
  localparam logic [SPEED_W-1:0]   MAX_SPD_RST = SPEED_W'(35);
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = SETTLE_W'(20);
  localparam logic [TIMEOUT_W-1:0] TMO_RST     = TIMEOUT_W'(250);
  localparam logic [SPEED_W-1:0]   HOLD_RST    = SPEED_W'(25);
  localparam logic [SPEED_W-1:0]   CRUISE_RST  = SPEED_W'(100);
  localparam logic [TRIM_W-1:0]    TRIM_RST    = TRIM_W'(8);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_TURN     = 2'd1,
    OP_STRAIGHT = 2'd2
  } op_t;

  // segment kinds
  typedef enum logic [1:0] {
    KIND_IDLE     = 2'd0,
    KIND_TURN     = 2'd1,
    KIND_STRAIGHT = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_TOL     = 3'd0,
    REG_TURN_MIN     = 3'd1,
    REG_TURN_MAX     = 3'd2,
    REG_SETTLE       = 3'd3,
    REG_TURN_TIMEOUT = 3'd4,
    REG_HOLD_MAX     = 3'd5,
    REG_CRUISE       = 3'd6,
    REG_LEFT_TRIM    = 3'd7
  } cfg_reg_t;

endpackage

// ===== design/heading_turn_and_hold_controller_core.sv =====
// ----------------------------------------------------------------------------
// heading_turn_and_hold_controller_core
// Proportional heading controller: in-place turns with settle and timeout,
// straight segments with heading hold, and wheel odometry.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one beat per 10 ms tick or per segment start. tuser holds the
//   operation (tick, start turn, start straight); tdata holds the heading,
//   the segment targets and the encoder deltas.
//   m_* channel: one result beat per input beat, in order: wheel speeds and
//   travelled count in tdata, segment finished on tlast, turn timeout on tuser.
//   cfg_*: register writes, taken whenever cfg_write is high; write only
//   while no beat is in flight.
// Timing
//   A beat lands in the input register, the controller arithmetic is
//   combinational, and the result register loads once the result slot is free,
//   raising m_tvalid. One beat per cycle sustained while m_tready stays high;
//   the combinational path runs from the odometer saturating add through the
//   travelled mean.
// Reset and stalls
//   rst clears the valid flags of both registers, the segment state (idle) and the odometers and
//   loads the register defaults. While m_tready is low the result is held and
//   one more beat may wait in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module heading_turn_and_hold_controller_core #(
  parameter int ODOMETER_BITS = hthc_pkg::ODOMETER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // slave stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // heading[13:0], target_heading[27:14], target_pulses[43:28],
  // lenc_step[55:44], renc_step[67:56], zero pad[71:68]
  input  logic [hthc_pkg::S_DATA_W-1:0]    s_tdata,
  // op[1:0]
  input  logic [hthc_pkg::OP_W-1:0]        s_tuser,
  // master stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // lwheel_cmd[8:0], rwheel_cmd[17:9], travelled_pulses[48:18], zero pad[55:49]
  output logic [hthc_pkg::M_DATA_W-1:0]    m_tdata,
  // segment_done
  output logic                             m_tlast,
  // timed_out
  output logic                             m_tuser,
  // configuration writes
  input  logic                             cfg_write,
  input  logic [hthc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hthc_pkg::CFG_W-1:0]       cfg_data
);
  import hthc_pkg::*;

  localparam int ODO_W = ODOMETER_BITS;
  localparam int EXT_W = (ODO_W > TRAV_W) ? ODO_W : TRAV_W;
  localparam logic signed [ODO_W-1:0] ODO_MAX = {1'b0, {(ODO_W-1){1'b1}}};
  localparam logic signed [ODO_W-1:0] ODO_MIN = {1'b1, {(ODO_W-1){1'b0}}};

  // configuration registers
  logic [TOL_W-1:0]     turn_tolerance;
  logic [SPEED_W-1:0]   turn_min_speed;
  logic [SPEED_W-1:0]   turn_max_speed;
  logic [SETTLE_W-1:0]  settle_ticks;
  logic [TIMEOUT_W-1:0] turn_timeout_ticks;
  logic [SPEED_W-1:0]   hold_max_correction;
  logic [SPEED_W-1:0]   cruise_speed;
  logic [TRIM_W-1:0]    left_trim;

  // input register
  logic                       in_vld;
  logic [OP_W-1:0]            in_op;
  logic signed [HEAD_W-1:0]   in_heading;
  logic signed [HEAD_W-1:0]   in_target_heading;
  logic [PULSE_W-1:0]         in_target_pulses;
  logic signed [DELTA_W-1:0]  in_lenc_step;
  logic signed [DELTA_W-1:0]  in_renc_step;

  // controller state
  kind_t                      kind, kind_next;
  logic signed [HEAD_W-1:0]   goal_heading, goal_heading_next;
  logic [PULSE_W-1:0]         goal_pulses, goal_pulses_next;
  logic [SETTLE_W-1:0]        settle_count, settle_count_next;
  logic [TIMEOUT_W-1:0]       timeout_count, timeout_count_next;
  logic signed [ODO_W-1:0]    left_odometer, left_odometer_next;
  logic signed [ODO_W-1:0]    right_odometer, right_odometer_next;

  // result register
  logic signed [SPD_W-1:0]    res_left, res_left_next;
  logic signed [SPD_W-1:0]    res_right, res_right_next;
  logic                       res_done, res_done_next;
  logic                       res_tmo, res_tmo_next;
  logic [TRAV_W-1:0]          res_trav, res_trav_next;

  // handshake
  logic out_free;
  logic advance;
  logic s_fire;

  // datapath
  logic signed [ERR_W-1:0]      err_raw;
  logic signed [ERR_W-1:0]      err_wrap;
  logic [ERR_W-1:0]             err_mag;
  logic [ABS_W-1:0]             err_abs;
  logic                         in_band;
  logic [TURN_NUM_W-1:0]        turn_num;
  logic [TURN_NUM_W+RECIP_W-1:0] turn_prod;
  logic [TURN_Q_W-1:0]          turn_q;
  logic [TURN_Q_W-1:0]          turn_hi;
  logic [SPEED_W-1:0]           turn_spd;
  logic signed [SPD_W-1:0]      turn_pos;
  logic signed [ERR_W-1:0]      err_biased;
  logic signed [ERR_W-1:0]      corr_raw;
  logic signed [ERR_W-1:0]      lim_pos;
  logic signed [ERR_W-1:0]      lim_neg;
  logic signed [ERR_W-1:0]      corr_lim;
  logic signed [SUM_W-1:0]      corr;
  logic signed [SUM_W-1:0]      cruise_s;
  logic signed [SUM_W-1:0]      lsum;
  logic signed [SUM_W-1:0]      rsum;
  logic [SPEED_W-1:0]           lclamp;
  logic [SPEED_W-1:0]           rclamp;
  logic signed [SPD_W-1:0]      hold_left;
  logic signed [SPD_W-1:0]      hold_right;
  logic signed [ODO_W:0]        lodo_sum;
  logic signed [ODO_W:0]        rodo_sum;
  logic signed [ODO_W-1:0]      lodo_sat;
  logic signed [ODO_W-1:0]      rodo_sat;
  logic signed [ODO_W-1:0]      lodo_upd;
  logic signed [ODO_W-1:0]      rodo_upd;
  logic [ODO_W-1:0]             lodo_mag;
  logic [ODO_W-1:0]             rodo_mag;
  logic [ODO_W:0]               mag_sum;
  logic [EXT_W-1:0]             mean_ext;
  logic [TRAV_W-1:0]            trav;
  logic                         trav_reached;
  logic [SETTLE_W-1:0]          settle_inc;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_tolerance      <= TOL_RST;
      turn_min_speed      <= MIN_SPD_RST;
      turn_max_speed      <= MAX_SPD_RST;
      settle_ticks        <= SETTLE_RST;
      turn_timeout_ticks  <= TMO_RST;
      hold_max_correction <= HOLD_RST;
      cruise_speed        <= CRUISE_RST;
      left_trim           <= TRIM_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TURN_TOL:     turn_tolerance      <= cfg_data[TOL_W-1:0];
        REG_TURN_MIN:     turn_min_speed      <= cfg_data[SPEED_W-1:0];
        REG_TURN_MAX:     turn_max_speed      <= cfg_data[SPEED_W-1:0];
        REG_SETTLE:       settle_ticks        <= cfg_data[SETTLE_W-1:0];
        REG_TURN_TIMEOUT: turn_timeout_ticks  <= cfg_data[TIMEOUT_W-1:0];
        REG_HOLD_MAX:     hold_max_correction <= cfg_data[SPEED_W-1:0];
        REG_CRUISE:       cruise_speed        <= cfg_data[SPEED_W-1:0];
        REG_LEFT_TRIM:    left_trim           <= cfg_data[TRIM_W-1:0];
      endcase
    end
  end

  // handshake: input register moves on whenever the result slot is free
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_vld && out_free;
  assign s_tready = !in_vld || out_free;
  assign s_fire   = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_fire) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_op             <= s_tuser;
      in_heading        <= s_tdata[13:0];
      in_target_heading <= s_tdata[27:14];
      in_target_pulses  <= s_tdata[43:28];
      in_lenc_step      <= s_tdata[55:44];
      in_renc_step      <= s_tdata[67:56];
    end
  end

  // heading error wrapped into plus or minus half a turn
  always_comb begin
    err_raw  = ERR_W'(goal_heading) - ERR_W'(in_heading);
    err_wrap = err_raw;
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (err_wrap > HALF_TURN_E) begin
        err_wrap = err_wrap - FULL_TURN_E;
      end else if (err_wrap < NEG_HALF_TURN_E) begin
        err_wrap = err_wrap + FULL_TURN_E;
      end
    end
    err_mag = err_wrap[ERR_W-1] ? ERR_W'(-err_wrap) : ERR_W'(err_wrap);
    err_abs = err_mag[ABS_W-1:0];
    in_band = err_abs <= turn_tolerance;
  end

  // turn speed: 0.8 per degree of error via reciprocal multiply, then clamp
  always_comb begin
    turn_num  = {err_abs, 2'b00};
    turn_prod = (TURN_NUM_W+RECIP_W)'(turn_num) * (TURN_NUM_W+RECIP_W)'(TURN_RECIP);
    turn_q    = turn_prod[TURN_SHIFT +: TURN_Q_W];
    turn_hi   = (turn_q > TURN_Q_W'(turn_max_speed)) ? TURN_Q_W'(turn_max_speed) : turn_q;
    turn_spd  = (turn_hi < TURN_Q_W'(turn_min_speed)) ? turn_min_speed
                                                      : turn_hi[SPEED_W-1:0];
    turn_pos  = SPD_W'(turn_spd);
  end

  // heading hold: 0.5 per degree of error, truncated toward zero, then limited and applied around cruise
  always_comb begin
    err_biased = err_wrap + (err_wrap[ERR_W-1] ? ERR_W'(HOLD_BIAS) : ERR_W'(0));
    corr_raw   = err_biased >>> HOLD_SHIFT;
    lim_pos    = ERR_W'(hold_max_correction);
    lim_neg    = -lim_pos;
    if (corr_raw > lim_pos) begin
      corr_lim = lim_pos;
    end else if (corr_raw < lim_neg) begin
      corr_lim = lim_neg;
    end else begin
      corr_lim = corr_raw;
    end
    corr     = corr_lim[SUM_W-1:0];
    cruise_s = SUM_W'(cruise_speed);
    lsum     = cruise_s + corr;
    rsum     = cruise_s - corr;
    if (lsum < 0) begin
      lclamp = '0;
    end else if (lsum > SUM_W'(STRAIGHT_SPEED_CAP)) begin
      lclamp = SPEED_W'(STRAIGHT_SPEED_CAP);
    end else begin
      lclamp = lsum[SPEED_W-1:0];
    end
    if (rsum < 0) begin
      rclamp = '0;
    end else if (rsum > SUM_W'(STRAIGHT_SPEED_CAP)) begin
      rclamp = SPEED_W'(STRAIGHT_SPEED_CAP);
    end else begin
      rclamp = rsum[SPEED_W-1:0];
    end
    hold_left  = SPD_W'(lclamp) + SPD_W'(left_trim);
    hold_right = SPD_W'(rclamp);
  end

  // odometers: saturating accumulate on ticks, then mean absolute count
  always_comb begin
    lodo_sum = (ODO_W+1)'(left_odometer) + (ODO_W+1)'(in_lenc_step);
    rodo_sum = (ODO_W+1)'(right_odometer) + (ODO_W+1)'(in_renc_step);
    if (lodo_sum[ODO_W] != lodo_sum[ODO_W-1]) begin
      lodo_sat = lodo_sum[ODO_W] ? ODO_MIN : ODO_MAX;
    end else begin
      lodo_sat = lodo_sum[ODO_W-1:0];
    end
    if (rodo_sum[ODO_W] != rodo_sum[ODO_W-1]) begin
      rodo_sat = rodo_sum[ODO_W] ? ODO_MIN : ODO_MAX;
    end else begin
      rodo_sat = rodo_sum[ODO_W-1:0];
    end
    lodo_upd = (in_op == OP_TICK) ? lodo_sat : left_odometer;
    rodo_upd = (in_op == OP_TICK) ? rodo_sat : right_odometer;
    lodo_mag = lodo_upd[ODO_W-1] ? ODO_W'(-lodo_upd) : ODO_W'(lodo_upd);
    rodo_mag = rodo_upd[ODO_W-1] ? ODO_W'(-rodo_upd) : ODO_W'(rodo_upd);
    mag_sum  = {1'b0, lodo_mag} + {1'b0, rodo_mag};
    mean_ext = EXT_W'(mag_sum[ODO_W:1]);
    trav     = (mean_ext > EXT_W'(TRAVEL_MAX)) ? TRAVEL_MAX : mean_ext[TRAV_W-1:0];
    trav_reached = trav >= TRAV_W'(goal_pulses);
  end

  // segment control and result selection
  always_comb begin
    settle_inc = (settle_count == {SETTLE_W{1'b1}}) ? settle_count
                                                    : settle_count + SETTLE_W'(1);
    kind_next           = kind;
    goal_heading_next   = goal_heading;
    goal_pulses_next    = goal_pulses;
    settle_count_next   = settle_count;
    timeout_count_next  = timeout_count;
    left_odometer_next  = lodo_upd;
    right_odometer_next = rodo_upd;
    res_left_next       = '0;
    res_right_next      = '0;
    res_done_next       = 1'b0;
    res_tmo_next        = 1'b0;
    res_trav_next       = trav;
    case (in_op) inside
      OP_TURN, OP_STRAIGHT: begin
        kind_next           = (in_op == OP_TURN) ? KIND_TURN : KIND_STRAIGHT;
        goal_heading_next   = in_target_heading;
        goal_pulses_next    = in_target_pulses;
        settle_count_next   = '0;
        timeout_count_next  = turn_timeout_ticks;
        left_odometer_next  = '0;
        right_odometer_next = '0;
        res_trav_next       = '0;
      end
      OP_TICK: begin
        case (kind)
          KIND_TURN: begin
            if (timeout_count == '0) begin
              res_done_next = 1'b1;
              res_tmo_next  = 1'b1;
            end else begin
              timeout_count_next = timeout_count - TIMEOUT_W'(1);
              if (in_band) begin
                settle_count_next = settle_inc;
                res_done_next     = settle_inc >= settle_ticks;
              end else begin
                settle_count_next = '0;
                res_left_next     = (err_wrap > 0) ? turn_pos : -turn_pos;
                res_right_next    = (err_wrap > 0) ? -turn_pos : turn_pos;
              end
            end
            // finished turn: back to idle with clean odometers
            if (res_done_next) begin
              kind_next           = KIND_IDLE;
              left_odometer_next  = '0;
              right_odometer_next = '0;
            end
          end
          KIND_STRAIGHT: begin
            if (trav_reached) begin
              res_done_next = 1'b1;
              kind_next     = KIND_IDLE;
            end else begin
              res_left_next  = hold_left;
              res_right_next = hold_right;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // segment state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind           <= KIND_IDLE;
      goal_heading   <= '0;
      goal_pulses    <= '0;
      settle_count   <= '0;
      timeout_count  <= '0;
      left_odometer  <= '0;
      right_odometer <= '0;
    end else if (advance) begin
      kind           <= kind_next;
      goal_heading   <= goal_heading_next;
      goal_pulses    <= goal_pulses_next;
      settle_count   <= settle_count_next;
      timeout_count  <= timeout_count_next;
      left_odometer  <= left_odometer_next;
      right_odometer <= right_odometer_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_left  <= res_left_next;
      res_right <= res_right_next;
      res_done  <= res_done_next;
      res_tmo   <= res_tmo_next;
      res_trav  <= res_trav_next;
    end
  end

  assign m_tdata = {(M_DATA_W - TRAV_W - 2*SPD_W)'(0), res_trav, res_right, res_left};
  assign m_tlast = res_done;
  assign m_tuser = res_tmo;

  // a timeout always closes the segment
  a_tmo_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("timed_out without segment_done");

  // a finished segment leaves the controller idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res_done_next |=> kind == KIND_IDLE)
    else $error("segment finished but kind not idle");

  // start items report zero speeds and zero travel
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    advance && (in_op == OP_TURN || in_op == OP_STRAIGHT) |=>
      res_left == '0 && res_right == '0 && res_trav == '0 && !res_done)
    else $error("start item result not cleared");

  // an expired turn timer ends the turn by timeout on the next tick
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == OP_TICK && kind == KIND_TURN && timeout_count == '0 |=>
      m_tvalid && m_tuser && m_tlast)
    else $error("expired turn did not time out");

  // nothing is in flight right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid && !in_vld)
    else $error("pipeline not empty after reset");

endmodule
